>>> rtl/core/dtq_pkg.sv
package dtq_pkg;

	localparam logic [7:0]  QUOTE_BYTE  = 8'h22;
	localparam logic [7:0]  ESCAPE_BYTE = 8'h5C;

	localparam logic [63:0] DELIM_BYTES_RESET = 64'h0000_0000_0A0D_0920;
	localparam logic [3:0]  DELIM_COUNT_RESET = 4'd4;
	localparam logic        QUOTE_DETECT_RESET = 1'b1;

	localparam logic [1:0]  REG_DELIM_BYTES  = 2'd0;
	localparam logic [1:0]  REG_DELIM_COUNT  = 2'd1;
	localparam logic [1:0]  REG_QUOTE_DETECT = 2'd2;

	localparam int          QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		MODE_IDLE       = 2'd0,
		MODE_PLAIN      = 2'd1,
		MODE_QUOTED     = 2'd2,
		MODE_QUOTED_ESC = 2'd3
	} mode_t;

	typedef struct packed {
		logic [63:0] delim_bytes;
		logic [3:0]  delim_count;
		logic        quote_detect;
	} cfg_t;

	typedef struct packed {
		logic [7:0] token_byte;
		logic       byte_valid;
		logic       token_done;
		logic       from_quotes;
		logic [7:0] last_sep;
		logic       final_result;
	} res_t;

	typedef struct packed {
		logic [1:0] count;
		res_t       first;
		res_t       second;
	} push_t;

	typedef struct packed {
		logic [2:0] level;
		logic       room;
	} q_status_t;

endpackage

>>> rtl/core/delimiter_tokenizer_quoted.sv
// Byte tokenizer: one byte word per cycle enters an input register, where a parallel compare
// against up to MAX_DELIMS delimiter bytes and a four-state scan update produce zero, one or
// two result words (a token byte, a token end, or a byte followed by the end that the
// end-of-buffer flag forces). Results go out one word per cycle through a four-entry output
// queue, so input is taken every cycle as long as the output side keeps pace; an input word
// waits in the input register while the queue holds more than two words. A result word
// goes through the input register and the output queue to the output. Registers sit on a
// 64-bit APB-style port at byte addresses 0 (delimiter bytes), 8 (delimiter count) and 16
// (quote detection), and are to be written only while the block is idle.
module delimiter_tokenizer_quoted
	import dtq_pkg::*;
#(
	parameter int MAX_DELIMS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_in,
	input  logic        end_of_buffer,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  token_byte,
	output logic        byte_valid,
	output logic        token_done,
	output logic        from_quotes,
	output logic [7:0]  last_sep,
	output logic        final_result
);

	cfg_t      cfg;
	push_t     push;
	q_status_t q_status;
	res_t      head;

	dtq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dtq_scan #(
		.MAX_DELIMS (MAX_DELIMS)
	) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.char_in       (char_in),
		.end_of_buffer (end_of_buffer),
		.room          (q_status.room),
		.push          (push)
	);

	dtq_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.status    (q_status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign token_byte   = head.token_byte;
	assign byte_valid   = head.byte_valid;
	assign token_done   = head.token_done;
	assign from_quotes  = head.from_quotes;
	assign last_sep     = head.last_sep;
	assign final_result = head.final_result;

`ifndef SYNTHESIS
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.level <= 3'(QUEUE_DEPTH))
		else $error("output queue level above its depth");

	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (q_status.level > 3'(QUEUE_DEPTH - 2)))
		else $error("input stalled while the output queue has room");

	a_hold_on_out_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (q_status.level >= $past(q_status.level)))
		else $error("output queue lost a word while stalled");
`endif

endmodule

>>> rtl/core/dtq_cfg.sv
module dtq_cfg
	import dtq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [63:0] delim_bytes_q;
	logic [3:0]  delim_count_q;
	logic        quote_detect_q;
	logic [1:0]  reg_idx;
	logic        wr_en;

	assign reg_idx = paddr[4:3];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_bytes_q  <= DELIM_BYTES_RESET;
			delim_count_q  <= DELIM_COUNT_RESET;
			quote_detect_q <= QUOTE_DETECT_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_DELIM_BYTES:  delim_bytes_q  <= pwdata;
				REG_DELIM_COUNT:  delim_count_q  <= pwdata[3:0];
				REG_QUOTE_DETECT: quote_detect_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DELIM_BYTES:  prdata = delim_bytes_q;
			REG_DELIM_COUNT:  prdata = {60'd0, delim_count_q};
			REG_QUOTE_DETECT: prdata = {63'd0, quote_detect_q};
			default:          prdata = 64'd0;
		endcase
	end

	assign cfg.delim_bytes  = delim_bytes_q;
	assign cfg.delim_count  = delim_count_q;
	assign cfg.quote_detect = quote_detect_q;

endmodule

>>> rtl/core/dtq_scan.sv
module dtq_scan
	import dtq_pkg::*;
#(
	parameter int MAX_DELIMS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_in,
	input  logic       end_of_buffer,
	input  logic       room,
	output push_t      push
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eob_s1;

	mode_t      mode_q, mode_d, mid_mode;
	logic [7:0] recent_q, recent_d;
	logic       qflag_q, qflag_d;

	logic       advance;
	logic       accept;
	logic       is_delim;
	logic [3:0] cnt_sat;

	logic       first_has;
	logic [7:0] first_byte;
	logic       first_valid;
	logic       first_done;
	logic       close_at_end;
	res_t       byte_res, done_res;

	assign advance  = valid_s1 & room;
	assign in_stall = valid_s1 & ~room;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_in;
			eob_s1  <= end_of_buffer;
		end
	end

	// Counts above the number of compare lanes saturate.
	assign cnt_sat = (cfg.delim_count > 4'(MAX_DELIMS)) ? 4'(MAX_DELIMS) : cfg.delim_count;

	always_comb begin
		is_delim = 1'b0;
		for (int i = 0; i < MAX_DELIMS; i++) begin
			if ((4'(i) < cnt_sat) && (cfg.delim_bytes[8*i +: 8] == char_s1)) begin
				is_delim = 1'b1;
			end
		end
	end

	// Next state.
	always_comb begin
		mid_mode = mode_q;
		recent_d = recent_q;
		qflag_d  = qflag_q;
		case (mode_q)
			MODE_IDLE: begin
				if (is_delim) begin
					recent_d = char_s1;
				end else if (char_s1 == QUOTE_BYTE && cfg.quote_detect) begin
					qflag_d  = 1'b1;
					mid_mode = MODE_QUOTED;
				end else begin
					qflag_d  = 1'b0;
					mid_mode = MODE_PLAIN;
				end
			end
			MODE_PLAIN: begin
				if (is_delim) begin
					recent_d = char_s1;
					mid_mode = MODE_IDLE;
				end
			end
			MODE_QUOTED: begin
				if (char_s1 == QUOTE_BYTE) begin
					mid_mode = MODE_IDLE;
				end else if (char_s1 == ESCAPE_BYTE) begin
					mid_mode = MODE_QUOTED_ESC;
				end
			end
			default: begin
				mid_mode = MODE_QUOTED;
			end
		endcase
		mode_d = eob_s1 ? MODE_IDLE : mid_mode;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			recent_q <= 8'd0;
			qflag_q  <= 1'b0;
		end else if (advance) begin
			mode_q   <= mode_d;
			recent_q <= recent_d;
			qflag_q  <= qflag_d;
		end
	end

	// Outputs.
	always_comb begin
		first_has   = 1'b0;
		first_byte  = 8'd0;
		first_valid = 1'b0;
		first_done  = 1'b0;
		case (mode_q)
			MODE_IDLE: begin
				if (!is_delim && !(char_s1 == QUOTE_BYTE && cfg.quote_detect)) begin
					first_has   = 1'b1;
					first_byte  = char_s1;
					first_valid = 1'b1;
				end
			end
			MODE_PLAIN: begin
				first_has = 1'b1;
				if (is_delim) begin
					first_done = 1'b1;
				end else begin
					first_byte  = char_s1;
					first_valid = 1'b1;
				end
			end
			MODE_QUOTED: begin
				first_has = 1'b1;
				if (char_s1 == QUOTE_BYTE) begin
					first_done = 1'b1;
				end else begin
					first_byte  = char_s1;
					first_valid = 1'b1;
				end
			end
			default: begin
				first_has   = 1'b1;
				first_byte  = char_s1;
				first_valid = 1'b1;
			end
		endcase

		// A buffer that ends inside a token closes it with an extra word.
		close_at_end = eob_s1 && (mid_mode != MODE_IDLE);

		byte_res.token_byte   = first_byte;
		byte_res.byte_valid   = first_valid;
		byte_res.token_done   = first_done;
		byte_res.from_quotes  = qflag_d;
		byte_res.last_sep     = recent_d;
		byte_res.final_result = ~close_at_end;

		done_res.token_byte   = 8'd0;
		done_res.byte_valid   = 1'b0;
		done_res.token_done   = 1'b1;
		done_res.from_quotes  = qflag_d;
		done_res.last_sep     = recent_d;
		done_res.final_result = 1'b1;

		push.first  = first_has ? byte_res : done_res;
		push.second = done_res;
		if (!advance) begin
			push.count = 2'd0;
		end else begin
			push.count = {1'b0, first_has} + {1'b0, close_at_end};
		end
	end

endmodule

>>> rtl/core/dtq_outq.sv
module dtq_outq
	import dtq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  push_t     push,
	output q_status_t status,
	output logic      out_valid,
	input  logic      out_stall,
	output res_t      head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

	res_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
	logic [LVL_W-1:0] level_q;
	logic             pop;

	assign out_valid = (level_q != '0);
	assign pop       = out_valid & ~out_stall;
	assign head      = entry_q[rd_ptr_q];
	assign wr_ptr_nx = wr_ptr_q + PTR_W'(1);

	assign status.level = 3'(level_q);
	// Room is judged without the pop of this cycle, so a word can always take two slots.
	assign status.room  = (level_q <= LVL_W'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			level_q <= level_q + LVL_W'(push.count) - LVL_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_ptr_nx] <= push.second;
		end
	end

endmodule
